// File: rtl/core/gbpf_pkg.sv
// Shared types and constants for the gcd by prime factorization block.
package gbpf_pkg;

	typedef enum logic [1:0] {
		KIND_FIRST  = 2'd0,
		KIND_SECOND = 2'd1,
		KIND_GCD    = 2'd2
	} kind_t;

	typedef enum logic {
		UOP_DIV,
		UOP_MUL
	} unit_op_t;

	typedef struct packed {
		logic     start;
		unit_op_t op;
	} unit_req_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV_A,
		S_WAIT_A,
		S_DIV_B,
		S_WAIT_B,
		S_DECIDE,
		S_MUL,
		S_WAIT_MUL,
		S_EMIT_A,
		S_EMIT_B,
		S_FIN,
		S_EMIT_GCD
	} state_t;

	localparam int FIRST_DIVISOR = 2;

endpackage

// File: rtl/core/gbpf_if.sv
// Operand and result channel interfaces for the gcd by prime factorization block.
interface gbpf_in_if #(parameter int W = 31) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] first_operand;
	logic [W-1:0] second_operand;

	modport source (output valid, output first_operand, output second_operand, input ready);
	modport sink (input valid, input first_operand, input second_operand, output ready);
endinterface

interface gbpf_out_if #(parameter int W = 31) ();
	logic         valid;
	logic         ready;
	logic [1:0]   kind;
	logic [W-1:0] value;
	logic         last;

	modport source (output valid, output kind, output value, output last, input ready);
	modport sink (input valid, input kind, input value, input last, output ready);
endinterface

// File: rtl/core/gbpf_unit.sv
// Shared bit-serial unit: restoring division or shift-add multiply, one bit a cycle.
module gbpf_unit #(
	parameter int W = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gbpf_pkg::unit_req_t req,
	input  logic [W-1:0]        opa,
	input  logic [W-1:0]        opb,
	output logic                done,
	output logic [W-1:0]        quo,
	output logic [W-1:0]        rem,
	output logic [W-1:0]        prod
);
	import gbpf_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	unit_op_t      mode_q;
	logic [W:0]    acc_q;
	logic [W-1:0]  sh_q;
	logic [W-1:0]  opb_q;

	logic [W:0]    shifted;
	logic [W+1:0]  add_x;
	logic [W+1:0]  add_y;
	logic [W+1:0]  sum;
	logic          ge;
	logic [W:0]    acc_next;

	// One adder serves both operations: subtract-compare when dividing,
	// add of the multiplicand when multiplying.
	always_comb begin
		shifted = {acc_q[W-1:0], sh_q[W-1]};
		if (mode_q == UOP_DIV) begin
			add_x = {1'b0, shifted};
			add_y = ~{2'b00, opb_q};
		end else begin
			add_x = {1'b0, acc_q[W-1:0], 1'b0};
			add_y = sh_q[W-1] ? {2'b00, opb_q} : '0;
		end
		sum = add_x + add_y + {{(W+1){1'b0}}, (mode_q == UOP_DIV)};
		ge  = ~sum[W+1];
		if (mode_q == UOP_DIV) begin
			acc_next = ge ? sum[W:0] : shifted;
		end else begin
			acc_next = {1'b0, sum[W-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			mode_q <= UOP_DIV;
		end else if (req.start) begin
			cnt_q  <= CW'(W);
			mode_q <= req.op;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			sh_q  <= opa;
			opb_q <= opb;
		end else if (cnt_q != '0) begin
			acc_q <= acc_next;
			sh_q  <= {sh_q[W-2:0], (mode_q == UOP_DIV) & ge};
		end
	end

	assign done = (cnt_q == '0);
	assign quo  = sh_q;
	assign rem  = acc_q[W-1:0];
	assign prod = acc_q[W-1:0];

endmodule

// File: rtl/core/gcd_by_prime_factorization.sv
// Top level: trial-division factoring sequencer with gcd accumulation.
//
//   channel     dir   payload                              last item of a run
//   operands    in    first_operand, second_operand        -
//   results     out   kind, value, last                    kind gcd, last = 1
//
// Each trial divisor costs two divisions on the shared bit-serial unit,
// plus a multiply for each common factor taken into the gcd and an emit
// state for each factor emitted. The trial divisor stops near the square
// root of the larger residual. The operand channel is ready only while no
// run is in progress; a stalled result holds the sequencer in its emit
// state. Reset clears the sequencer.
module gcd_by_prime_factorization #(
	parameter int OPERAND_WIDTH = 31
) (
	input logic       clk,
	input logic       arst_n,
	gbpf_in_if.sink   operands,
	gbpf_out_if.source results
);
	import gbpf_pkg::*;

	localparam int W = OPERAND_WIDTH;

	state_t       state_q;
	state_t       state_d;

	logic [W-1:0] ra_q;
	logic [W-1:0] rb_q;
	logic [W-1:0] p_q;
	logic [W-1:0] g_q;
	logic [W-1:0] qa_q;
	logic [W-1:0] qb_q;
	logic         za_q;
	logic         zb_q;
	logic         fin_q;

	logic         ov_q;
	kind_t        okind_q;
	logic [W-1:0] ovalue_q;
	logic         olast_q;

	unit_req_t    req;
	logic [W-1:0] u_opa;
	logic [W-1:0] u_opb;
	logic         u_done;
	logic [W-1:0] u_quo;
	logic [W-1:0] u_rem;
	logic [W-1:0] u_prod;

	logic         accept;
	logic         zero_in;
	logic         slot_free;
	logic         stop;
	logic         a_big;
	logic         b_big;
	logic         emit;
	kind_t        emit_kind;
	logic [W-1:0] emit_value;

	gbpf_unit #(.W(W)) u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.opa    (u_opa),
		.opb    (u_opb),
		.done   (u_done),
		.quo    (u_quo),
		.rem    (u_rem),
		.prod   (u_prod)
	);

	assign accept    = operands.valid && operands.ready;
	assign zero_in   = (operands.first_operand == '0) || (operands.second_operand == '0);
	assign slot_free = !ov_q || results.ready;
	assign stop      = (qa_q < p_q) && (qb_q < p_q);
	assign a_big     = (ra_q[W-1:1] != '0);
	assign b_big     = (rb_q[W-1:1] != '0);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = zero_in ? S_EMIT_GCD : S_DIV_A;
			end
			S_DIV_A:  state_d = S_WAIT_A;
			S_WAIT_A: if (u_done) state_d = S_DIV_B;
			S_DIV_B:  state_d = S_WAIT_B;
			S_WAIT_B: if (u_done) state_d = S_DECIDE;
			S_DECIDE: begin
				priority if (stop)        state_d = S_FIN;
				else if (za_q && zb_q)    state_d = S_MUL;
				else if (za_q)            state_d = S_EMIT_A;
				else if (zb_q)            state_d = S_EMIT_B;
				else                      state_d = S_DIV_A;
			end
			S_MUL:      state_d = S_WAIT_MUL;
			S_WAIT_MUL: if (u_done) state_d = S_EMIT_A;
			S_EMIT_A: begin
				if (slot_free) begin
					priority if (fin_q) state_d = S_FIN;
					else if (zb_q)      state_d = S_EMIT_B;
					else                state_d = S_DIV_A;
				end
			end
			S_EMIT_B: begin
				if (slot_free) state_d = fin_q ? S_FIN : S_DIV_A;
			end
			S_FIN: begin
				// Leftover residuals are 1 or primes: emit the smaller first,
				// and a shared leftover prime also goes into the gcd.
				priority if (a_big && ra_q == rb_q)          state_d = S_MUL;
				else if (a_big && (!b_big || ra_q < rb_q))   state_d = S_EMIT_A;
				else if (b_big)                              state_d = S_EMIT_B;
				else                                         state_d = S_EMIT_GCD;
			end
			S_EMIT_GCD: if (slot_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		operands.ready = 1'b0;
		req.start      = 1'b0;
		req.op         = UOP_DIV;
		u_opa          = ra_q;
		u_opb          = p_q;
		emit           = 1'b0;
		emit_kind      = KIND_GCD;
		emit_value     = g_q;
		unique case (state_q)
			S_IDLE: operands.ready = 1'b1;
			S_DIV_A: begin
				req.start = 1'b1;
			end
			S_DIV_B: begin
				req.start = 1'b1;
				u_opa     = rb_q;
			end
			S_MUL: begin
				req.start = 1'b1;
				req.op    = UOP_MUL;
				u_opa     = g_q;
				u_opb     = fin_q ? ra_q : p_q;
			end
			S_EMIT_A: begin
				emit       = slot_free;
				emit_kind  = KIND_FIRST;
				emit_value = fin_q ? ra_q : p_q;
			end
			S_EMIT_B: begin
				emit       = slot_free;
				emit_kind  = KIND_SECOND;
				emit_value = fin_q ? rb_q : p_q;
			end
			S_EMIT_GCD: emit = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fin_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				fin_q <= 1'b0;
			end else if (state_q == S_DECIDE && stop) begin
				fin_q <= 1'b1;
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (results.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ra_q <= operands.first_operand;
			rb_q <= operands.second_operand;
			p_q  <= W'(FIRST_DIVISOR);
			g_q  <= zero_in ? '0 : W'(1);
		end
		if (state_q == S_WAIT_A && u_done) begin
			qa_q <= u_quo;
			za_q <= (u_rem == '0);
		end
		if (state_q == S_WAIT_B && u_done) begin
			qb_q <= u_quo;
			zb_q <= (u_rem == '0);
		end
		if (state_q == S_DECIDE && !stop && !za_q && !zb_q) begin
			p_q <= p_q + W'(1);
		end
		if (state_q == S_WAIT_MUL && u_done) begin
			g_q <= u_prod;
		end
		if (state_q == S_EMIT_A && slot_free) begin
			ra_q <= fin_q ? W'(1) : qa_q;
		end
		if (state_q == S_EMIT_B && slot_free) begin
			rb_q <= fin_q ? W'(1) : qb_q;
		end
		if (emit) begin
			okind_q  <= emit_kind;
			ovalue_q <= emit_value;
			olast_q  <= (emit_kind == KIND_GCD);
		end
	end

	assign results.valid = ov_q;
	assign results.kind  = okind_q;
	assign results.value = ovalue_q;
	assign results.last  = olast_q;

endmodule

// File: rtl/core/gbpf_checker.sv
// Port-level assertions for the gcd by prime factorization block, with its bind.
module gbpf_checker #(
	parameter int W = 31
) (
	input logic         clk,
	input logic         arst_n,
	input logic         in_valid,
	input logic         in_ready,
	input logic         out_valid,
	input logic         out_ready,
	input logic [1:0]   out_kind,
	input logic [W-1:0] out_value,
	input logic         out_last
);
	import gbpf_pkg::*;

	// A result that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
			$stable(out_value) && $stable(out_last))
		else $error("stalled result item changed");

	// Only one run at a time: after an item is taken the block is busy.
	a_one_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("operand channel ready right after an accepted item");

	// The gcd result, and only it, closes a run.
	a_last_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_last == (out_kind == KIND_GCD)))
		else $error("last flag does not match the gcd result");

	// A factor is only shown while its run is still in progress.
	a_factor_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != KIND_GCD |-> !in_ready)
		else $error("factor pending while operand channel ready");

	// Every factor is at least two.
	a_factor_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != KIND_GCD |-> out_value[W-1:1] != '0)
		else $error("factor below two");

endmodule

bind gcd_by_prime_factorization gbpf_checker #(.W(OPERAND_WIDTH)) u_gbpf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (operands.valid),
	.in_ready  (operands.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_kind  (results.kind),
	.out_value (results.value),
	.out_last  (results.last)
);

// File: dv/testbench.sv
// Self-checking testbench for the gcd by prime factorization block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import gbpf_pkg::*;

	localparam int OPERAND_WIDTH = 31;
	localparam int CYCLE_LIMIT   = 30_000_000;
	localparam int TAIL_CYCLES   = 60;
	localparam int MAX_IDLE      = 4;

	typedef logic [OPERAND_WIDTH-1:0] operand_t;

	typedef struct packed {
		kind_t    kind;
		operand_t value;
		logic     last;
	} factor_result_t;

	logic clk = 1'b0;
	logic arst_n;

	gbpf_in_if  #(.W(OPERAND_WIDTH)) operands_ch ();
	gbpf_out_if #(.W(OPERAND_WIDTH)) results_ch ();

	gcd_by_prime_factorization #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (operands_ch),
		.results  (results_ch)
	);

	factor_result_t expected_factors[$];
	int             mismatch_count = 0;
	int             cycle_count    = 0;
	bit             idle_enabled   = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("gcd_by_prime_factorization test failed");
			$finish;
		end
	end

	function automatic void expect_result(kind_t kind, longint unsigned value, logic last);
		factor_result_t entry;
		entry.kind  = kind;
		entry.value = operand_t'(value);
		entry.last  = last;
		expected_factors.push_back(entry);
	endfunction

	// Trial division with a divisor that steps by one; a divisor that divides
	// either residual is tried again before moving on.
	function automatic void predict_factorization(operand_t first, operand_t second);
		longint unsigned res_a;
		longint unsigned res_b;
		longint unsigned divisor;
		longint unsigned gcd;
		bit              div_a;
		bit              div_b;
		res_a   = first;
		res_b   = second;
		divisor = FIRST_DIVISOR;
		gcd     = 1;
		if (res_a == 0 || res_b == 0) begin
			expect_result(KIND_GCD, 0, 1'b1);
			return;
		end
		while (!(res_a / divisor < divisor && res_b / divisor < divisor)) begin
			div_a = (res_a % divisor) == 0;
			div_b = (res_b % divisor) == 0;
			if (div_a && div_b)
				gcd = gcd * divisor;
			if (div_a) begin
				expect_result(KIND_FIRST, divisor, 1'b0);
				res_a = res_a / divisor;
			end
			if (div_b) begin
				expect_result(KIND_SECOND, divisor, 1'b0);
				res_b = res_b / divisor;
			end
			if (!div_a && !div_b)
				divisor = divisor + 1;
		end
		// What is left of each residual is either 1 or a prime; they leave in
		// ascending order, the first operand's copy first when they are equal.
		if (res_a > 1 && res_a == res_b) begin
			gcd = gcd * res_a;
			expect_result(KIND_FIRST, res_a, 1'b0);
			expect_result(KIND_SECOND, res_b, 1'b0);
		end else if (res_a > 1 && (res_b <= 1 || res_a < res_b)) begin
			expect_result(KIND_FIRST, res_a, 1'b0);
			if (res_b > 1)
				expect_result(KIND_SECOND, res_b, 1'b0);
		end else begin
			if (res_b > 1)
				expect_result(KIND_SECOND, res_b, 1'b0);
			if (res_a > 1)
				expect_result(KIND_FIRST, res_a, 1'b0);
		end
		expect_result(KIND_GCD, gcd, 1'b1);
	endfunction

	task automatic send_operands(input operand_t first, input operand_t second);
		int unsigned gap;
		gap = idle_enabled ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap > 0) begin
			operands_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operands_ch.valid          <= 1'b1;
		operands_ch.first_operand  <= first;
		operands_ch.second_operand <= second;
		do @(posedge clk); while (!operands_ch.ready);
		predict_factorization(first, second);
	endtask

	task automatic wait_for_results();
		operands_ch.valid <= 1'b0;
		while (expected_factors.size() != 0)
			@(posedge clk);
	endtask

	// Products of small factors keep the trial divisor, and so the run, short.
	function automatic operand_t grow_smooth(longint unsigned start, int unsigned steps);
		longint unsigned product;
		longint unsigned factor;
		int unsigned     bound;
		product = start;
		repeat (steps) begin
			bound  = ($urandom_range(0, 7) == 0) ? 1000 : 50;
			factor = $urandom_range(2, bound);
			if (product * factor < (64'd1 << OPERAND_WIDTH))
				product = product * factor;
		end
		return operand_t'(product);
	endfunction

	function automatic operand_t narrow_operand();
		int unsigned width;
		operand_t    value;
		width = $urandom_range(1, 16);
		value = operand_t'($urandom & ((32'd1 << width) - 32'd1));
		if (value == 0)
			value = 1;
		return value;
	endfunction

	task automatic draw_operand_pair(output operand_t first, output operand_t second);
		operand_t common;
		case ($urandom_range(0, 9))
			0, 1: begin
				first  = narrow_operand();
				second = narrow_operand();
			end
			2: begin
				first  = grow_smooth(1, $urandom_range(0, 16));
				second = narrow_operand();
			end
			3: begin
				first  = narrow_operand();
				second = grow_smooth(1, $urandom_range(0, 16));
			end
			default: begin
				common = grow_smooth(1, $urandom_range(0, 4));
				first  = grow_smooth(common, $urandom_range(0, 12));
				second = grow_smooth(common, $urandom_range(0, 12));
			end
		endcase
	endtask

	// The all-ones operand is prime and would keep the block busy trying every
	// divisor up to its square root; the largest even value sets all bits but bit 0.
	task automatic test_field_extremes();
		send_operands(31'd1, 31'd1);
		send_operands(31'd1, 31'h7FFF_FFFE);
		send_operands(31'h7FFF_FFFE, 31'd1);
		send_operands(31'h7FFF_FFFE, 31'h7FFF_FFFE);
		send_operands(31'h4000_0000, 31'h4000_0000);
		send_operands(31'h4000_0000, 31'd1162261467);
		send_operands(31'd1610612736, 31'h4000_0000);
		wait_for_results();
	endtask

	task automatic test_leftover_primes();
		send_operands(31'd131042, 31'd196563);
		send_operands(31'd65521, 31'd65521);
		send_operands(31'd65498, 31'd65521);
		send_operands(31'd65521, 31'd98247);
		send_operands(31'd1, 31'd65521);
		send_operands(31'd32749, 31'd1);
		wait_for_results();
	endtask

	task automatic test_shared_factors();
		send_operands(31'd360, 31'd840);
		send_operands(31'd248832, 31'd17496);
		send_operands(31'd8633, 31'd8051);
		send_operands(31'd12, 31'd12);
		send_operands(31'd2, 31'd3);
		send_operands(31'd4, 31'd2);
		wait_for_results();
	endtask

	task automatic test_random_pairs(input int count);
		operand_t first;
		operand_t second;
		repeat (count) begin
			draw_operand_pair(first, second);
			send_operands(first, second);
		end
		wait_for_results();
	endtask

	task automatic test_back_to_back(input int count);
		operand_t first;
		operand_t second;
		idle_enabled = 1'b0;
		repeat (count) begin
			draw_operand_pair(first, second);
			send_operands(first, second);
		end
		wait_for_results();
		idle_enabled = 1'b1;
	endtask

	// Result side: each item gets its own stall before ready is raised.
	initial begin
		int unsigned stall;
		results_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = idle_enabled ? $urandom_range(0, MAX_IDLE) : 0;
			if (stall > 0) begin
				results_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results_ch.ready <= 1'b1;
			do @(posedge clk); while (!(results_ch.valid && results_ch.ready));
		end
	end

	always @(posedge clk) begin : check_results
		factor_result_t want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (expected_factors.size() == 0) begin
				$error("unexpected result: kind %0d value %0d last %0d",
					results_ch.kind, results_ch.value, results_ch.last);
				mismatch_count++;
			end else begin
				want = expected_factors.pop_front();
				if (results_ch.kind !== want.kind) begin
					$error("kind mismatch: expected %0d, got %0d", want.kind, results_ch.kind);
					mismatch_count++;
				end
				if (results_ch.value !== want.value) begin
					$error("value mismatch: expected %0d, got %0d", want.value, results_ch.value);
					mismatch_count++;
				end
				if (results_ch.last !== want.last) begin
					$error("last mismatch: expected %0d, got %0d", want.last, results_ch.last);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n                     <= 1'b0;
		operands_ch.valid          <= 1'b0;
		operands_ch.first_operand  <= '0;
		operands_ch.second_operand <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_leftover_primes();
		test_shared_factors();
		test_random_pairs(85);
		test_back_to_back(15);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_factors.size() == 0)
			$display("gcd_by_prime_factorization test passed");
		else
			$display("gcd_by_prime_factorization test failed");
		$finish;
	end

endmodule
